### hw/rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the rounded-rect shadow pixel block
// Fixed-point widths, register indexes, request types and the exp ROM.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int COORD_BITS      = 11;
  localparam int EXP_TABLE_DEPTH = 256;

  // coordinate divider: numerator (2*pix+1)*2^15 + s/2, quotient in Q.8
  localparam int NUM_W  = COORD_BITS + 16;
  localparam int Q_W    = NUM_W - 8;
  localparam int DIVC_W = Q_W + 11;
  localparam int P_W    = Q_W + 2;

  // distance path
  localparam int SQ_W   = 2 * Q_W + 2;
  localparam int H_W    = SQ_W / 2;
  localparam int D_W    = H_W;
  localparam int N9_W   = 2 * D_W + 4;
  localparam int DEN_W  = 22;

  // exponent t is kept below 2^T_BITS (8.0 in Q.8)
  localparam int T_BITS = 11;
  localparam int AW     = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
  localparam int IDX_W  = T_BITS + AW + 2;

  localparam int DIV_LAT  = Q_W + 1;
  localparam int SQRT_LAT = H_W;
  localparam int TDIV_LAT = T_BITS + 1;
  localparam int PIPE_LAT = DIV_LAT + 3 + SQRT_LAT + 3 + TDIV_LAT + 4;

  typedef enum logic [2:0] {
    REG_COLOR  = 3'd0,
    REG_EXTENT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_OFFX   = 3'd3,
    REG_OFFY   = 3'd4,
    REG_SCALE  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
  } in_req_t;

  typedef struct packed {
    logic [31:0] pixel_argb;
    logic [7:0]  pixel_alpha;
  } out_req_t;

  typedef logic [16:0] exp_rom_t [EXP_TABLE_DEPTH];

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef longint unsigned exp_int_t [8];
  localparam exp_int_t EXP_NEG_INT = '{
    64'd1073741824, 64'd395007542, 64'd145315154, 64'd53458458,
    64'd19666268,   64'd7234816,   64'd2661540,   64'd979126
  };

  // shift-and-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned num,
                                             longint unsigned dvs);
    longint unsigned q, r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= dvs) begin
        r    = r - dvs;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-8k/depth) in Q.16, series evaluated in Q.30 at elaboration
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    longint unsigned tq, ip, f, sum, term, inv, val;
    logic stop;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      tq   = udiv64(longint'(k) << 33, 64'(EXP_TABLE_DEPTH));
      ip   = (tq >> 30) & 64'd7;
      f    = tq & (ONE_Q30 - 64'd1);
      sum  = ONE_Q30;
      term = ONE_Q30;
      stop = 1'b0;
      for (int n = 1; n <= 24; n++) begin
        if (!stop) begin
          term = udiv64((term * f) >> 30, 64'(n));
          if (term == 64'd0) begin
            stop = 1'b1;
          end else begin
            sum = sum + term;
          end
        end
      end
      inv    = udiv64(64'd1 << 60, sum);
      val    = (inv * EXP_NEG_INT[ip[2:0]]) >> 30;
      rom[k] = 17'((val + (64'd1 << 13)) >> 14);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

### hw/rtl/rounded_rect_shadow_pixel.sv
// ----------------------------------------------------------------------------
// rounded_rect_shadow_pixel: one pixel of a rounded-rect drop-shadow sprite
// Gaussian falloff of the distance to a rounded core, premultiplied ARGB out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one request per pixel coordinate.
//   out channel (out_valid/out_ready/out_data): one result request per input,
//     in order: premultiplied ARGB and the raw shadow alpha.
//   cfg port (cfg_we/cfg_index/cfg_data): write color, extent, radius,
//     offsets and scale; write only while the pipe is empty. Unknown indexes
//     are dropped.
// Throughput: one pixel per cycle while the pipe is not stalled. At 11-bit coordinates
//   the depth is set by the two bit-per-stage units: the coordinate divider (20 stages)
//   and the square root (20 stages), plus the 12-stage exponent divider.
// Reset: synchronous, active high; clears all valid bits and loads the
//   default shadow style. No clearing pass; the exp ROM is a constant table.
// Stall: the whole pipe holds while the output register is full and the
//   receiver is not ready; in_ready follows, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rounded_rect_shadow_pixel (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rrs_pkg::in_req_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rrs_pkg::out_req_t out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int LAT = rrs_pkg::PIPE_LAT;

  // configuration registers
  logic [31:0] color;
  logic [6:0]  extent;
  logic [6:0]  radius;
  logic [6:0]  offx;
  logic [6:0]  offy;
  logic [10:0] scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      color  <= 32'h3608_1423;
      extent <= 7'd14;
      radius <= 7'd12;
      offx   <= 7'd0;
      offy   <= 7'd3;
      scale  <= 11'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrs_pkg::REG_COLOR:  color  <= cfg_data;
        rrs_pkg::REG_EXTENT: extent <= cfg_data[6:0];
        rrs_pkg::REG_RADIUS: radius <= cfg_data[6:0];
        rrs_pkg::REG_OFFX:   offx   <= cfg_data[6:0];
        rrs_pkg::REG_OFFY:   offy   <= cfg_data[6:0];
        rrs_pkg::REG_SCALE:  scale  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // derived shape constants: clamp, find the core centre and the exponent
  // denominator; registered, stable long before any request reaches them
  logic [6:0]               rad_c;
  logic [10:0]              s_c;
  logic signed [17:0]       cx, cy;
  logic [rrs_pkg::DEN_W-1:0] den;

  logic [6:0]               ext_next, rad_next;
  logic [10:0]              s_next;
  logic signed [17:0]       cx_next, cy_next;
  logic [rrs_pkg::DEN_W-1:0] den_next;
  logic signed [7:0]        ox, oy, aox, aoy, amax;
  logic [8:0]               margin;

  always_comb begin
    ext_next = (extent < 7'd1) ? 7'd1 : ((extent > 7'd64) ? 7'd64 : extent);
    rad_next = (radius > 7'd64) ? 7'd64 : radius;
    ox       = 8'(signed'(offx));
    oy       = 8'(signed'(offy));
    ox       = (ox < -8'sd32) ? -8'sd32 : ((ox > 8'sd32) ? 8'sd32 : ox);
    oy       = (oy < -8'sd32) ? -8'sd32 : ((oy > 8'sd32) ? 8'sd32 : oy);
    aox      = (ox < 0) ? -ox : ox;
    aoy      = (oy < 0) ? -oy : oy;
    amax     = (aox > aoy) ? aox : aoy;
    margin   = 9'(ext_next) + 9'(amax) + 9'(rad_next);
    cx_next  = ((18'(signed'({1'b0, margin})) + 18'(ox)) <<< 8) + 18'sd128;
    cy_next  = ((18'(signed'({1'b0, margin})) + 18'(oy)) <<< 8) + 18'sd128;
    s_next   = (scale < 11'd256) ? 11'd256 : scale;
    den_next = (ext_next >= 7'd3)
               ? (rrs_pkg::DEN_W'(ext_next) * rrs_pkg::DEN_W'(ext_next)) << 9
               : rrs_pkg::DEN_W'(4608);
  end

  always_ff @(posedge clk) begin
    rad_c <= rad_next;
    s_c   <= s_next;
    cx    <= cx_next;
    cy    <= cy_next;
    den   <= den_next;
  end

  // handshake: one global enable, advance unless the output register is full and out_ready is low
  logic           en;
  logic [LAT-1:0] vld;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // sample point per axis
  logic [rrs_pkg::Q_W-1:0] px_q, py_q;

  rrs_coord_div u_div_x (
    .clk (clk),
    .en  (en),
    .pix (rrs_pkg::COORD_BITS'(in_data.pixel_x)),
    .s   (s_c),
    .p   (px_q)
  );

  rrs_coord_div u_div_y (
    .clk (clk),
    .en  (en),
    .pix (rrs_pkg::COORD_BITS'(in_data.pixel_y)),
    .s   (s_c),
    .p   (py_q)
  );

  // distance beyond the core edge per axis, then the squared radius
  logic signed [rrs_pkg::P_W-1:0] dx, dy, adx, ady;
  logic [rrs_pkg::Q_W-1:0]        ax, ay;
  logic [2*rrs_pkg::Q_W-1:0]      sqx, sqy;
  logic [rrs_pkg::SQ_W-1:0]       sqs;

  always_comb begin
    dx  = signed'(rrs_pkg::P_W'(px_q)) - rrs_pkg::P_W'(cx);
    dy  = signed'(rrs_pkg::P_W'(py_q)) - rrs_pkg::P_W'(cy);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax  <= (adx > rrs_pkg::P_W'(128)) ? rrs_pkg::Q_W'(adx - rrs_pkg::P_W'(128)) : '0;
      ay  <= (ady > rrs_pkg::P_W'(128)) ? rrs_pkg::Q_W'(ady - rrs_pkg::P_W'(128)) : '0;
      sqx <= ax * ax;
      sqy <= ay * ay;
      sqs <= rrs_pkg::SQ_W'(sqx) + rrs_pkg::SQ_W'(sqy);
    end
  end

  logic [rrs_pkg::H_W-1:0] h;

  rrs_isqrt u_isqrt (
    .clk (clk),
    .en  (en),
    .v   (sqs),
    .r   (h)
  );

  // distance past the rounded corner and the exponent numerator
  logic [rrs_pkg::D_W-1:0]   d;
  logic [2*rrs_pkg::D_W-1:0] dsq;
  logic [rrs_pkg::N9_W-1:0]  n9;
  logic [rrs_pkg::D_W-1:0]   radq;

  assign radq = rrs_pkg::D_W'(rad_c) << 8;

  always_ff @(posedge clk) begin
    if (en) begin
      d   <= (h > radq) ? h - radq : '0;
      dsq <= d * d;
      n9  <= (rrs_pkg::N9_W'(dsq) << 3) + rrs_pkg::N9_W'(dsq) + rrs_pkg::N9_W'(den >> 1);
    end
  end

  // exponent t = n9 / den, one bit a stage; overflow means t >= 8.0
  localparam int TB = rrs_pkg::T_BITS;

  logic [rrs_pkg::N9_W-1:0] tn  [TB+1];
  logic [TB-1:0]            tq  [TB+1];
  logic                     tov [TB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      tn[0]  <= n9;
      tq[0]  <= '0;
      tov[0] <= n9 >= (rrs_pkg::N9_W'(den) << TB);
      for (int j = 1; j <= TB; j++) begin
        tov[j] <= tov[j-1];
        if (tn[j-1] >= (rrs_pkg::N9_W'(den) << (TB - j))) begin
          tn[j] <= tn[j-1] - (rrs_pkg::N9_W'(den) << (TB - j));
          tq[j] <= tq[j-1] | (TB'(1) << (TB - j));
        end else begin
          tn[j] <= tn[j-1];
          tq[j] <= tq[j-1];
        end
      end
    end
  end

  // nearest ROM entry, falloff, alpha, premultiplied channels
  logic [rrs_pkg::IDX_W-1:0] idx_full;
  logic                      rom_hit;
  logic [rrs_pkg::AW-1:0]    rom_addr;
  logic [16:0]               fall;
  logic [7:0]                alpha;
  logic [7:0]                alpha_next;
  logic [24:0]               af;
  logic [16:0]               xr, xg, xb;
  logic [7:0]                qr, qg, qb;

  assign idx_full = ((rrs_pkg::IDX_W'(tq[TB]) * rrs_pkg::IDX_W'(rrs_pkg::EXP_TABLE_DEPTH))
                     + (rrs_pkg::IDX_W'(1) << (TB - 1))) >> TB;

  always_comb begin
    af         = (25'(color[31:24]) * 25'(fall) + 25'd32768) >> 16;
    alpha_next = (af > 25'd255) ? 8'd255 : af[7:0];
    // x / 255 for x below 2^16 is (x + (x >> 8) + 1) >> 8
    xr = 17'(color[23:16]) * 17'(alpha) + 17'd127;
    xg = 17'(color[15:8])  * 17'(alpha) + 17'd127;
    xb = 17'(color[7:0])   * 17'(alpha) + 17'd127;
    qr = 8'((xr + (xr >> 8) + 17'd1) >> 8);
    qg = 8'((xg + (xg >> 8) + 17'd1) >> 8);
    qb = 8'((xb + (xb >> 8) + 17'd1) >> 8);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rom_hit  <= !tov[TB] && (idx_full < rrs_pkg::IDX_W'(rrs_pkg::EXP_TABLE_DEPTH));
      rom_addr <= rrs_pkg::AW'(idx_full);
      fall     <= rom_hit ? rrs_pkg::EXP_ROM[rom_addr] : 17'd0;
      alpha    <= alpha_next;
      out_data.pixel_alpha <= alpha;
      out_data.pixel_argb  <= (alpha == 8'd0) ? 32'd0 : {alpha, qr, qg, qb};
    end
  end

endmodule

### hw/rtl/rrs_coord_div.sv
// ----------------------------------------------------------------------------
// rrs_coord_div: sample point of one axis
// Pipelined restoring divider, one quotient bit per stage: p = round(num / s).
// ----------------------------------------------------------------------------
module rrs_coord_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [rrs_pkg::COORD_BITS-1:0] pix,
  input  logic [10:0]                    s,
  output logic [rrs_pkg::Q_W-1:0]        p
);

  logic [rrs_pkg::NUM_W-1:0] rem [rrs_pkg::Q_W+1];
  logic [rrs_pkg::Q_W-1:0]   quo [rrs_pkg::Q_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (rrs_pkg::NUM_W'({pix, 1'b1}) << 15) + rrs_pkg::NUM_W'(s >> 1);
      quo[0] <= '0;
      for (int j = 1; j <= rrs_pkg::Q_W; j++) begin
        if (rrs_pkg::DIVC_W'(rem[j-1]) >= (rrs_pkg::DIVC_W'(s) << (rrs_pkg::Q_W - j))) begin
          rem[j] <= rrs_pkg::NUM_W'(rrs_pkg::DIVC_W'(rem[j-1])
                    - (rrs_pkg::DIVC_W'(s) << (rrs_pkg::Q_W - j)));
          quo[j] <= quo[j-1] | (rrs_pkg::Q_W'(1) << (rrs_pkg::Q_W - j));
        end else begin
          rem[j] <= rem[j-1];
          quo[j] <= quo[j-1];
        end
      end
    end
  end

  assign p = quo[rrs_pkg::Q_W];

endmodule

### hw/rtl/rrs_isqrt.sv
// ----------------------------------------------------------------------------
// rrs_isqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(v)).
// ----------------------------------------------------------------------------
module rrs_isqrt (
  input  logic                     clk,
  input  logic                     en,
  input  logic [rrs_pkg::SQ_W-1:0] v,
  output logic [rrs_pkg::H_W-1:0]  r
);

  localparam int K = rrs_pkg::H_W;

  logic [rrs_pkg::SQ_W-1:0] vv [K+1];
  logic [rrs_pkg::SQ_W-1:0] rr [K+1];

  assign vv[0] = v;
  assign rr[0] = '0;

  for (genvar k = 1; k <= K; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (vv[k-1] >= rrs_pkg::SQ_W'(rr[k-1] + (rrs_pkg::SQ_W'(1) << (2 * (K - k))))) begin
          vv[k] <= rrs_pkg::SQ_W'(vv[k-1] - rr[k-1] - (rrs_pkg::SQ_W'(1) << (2 * (K - k))));
          rr[k] <= rrs_pkg::SQ_W'((rr[k-1] >> 1) + (rrs_pkg::SQ_W'(1) << (2 * (K - k))));
        end else begin
          vv[k] <= vv[k-1];
          rr[k] <= rr[k-1] >> 1;
        end
      end
    end
  end

  assign r = rrs_pkg::H_W'(rr[K]);

endmodule
